/* rtl/cft_pkg.sv */
// Shared types, constants and helpers for the CSV field tokenizer.
`default_nettype none

package cft_pkg;

    // Default depth of the field buffer, in bytes
    localparam int FIELD_DEPTH_DEF = 64;

    // Special characters
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] COMMA_BYTE = 8'h2C;

    // Input command codes (carried on s_tuser)
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic take;    // input word accepted this cycle
        logic start;   // latch emit window and clear field state
        logic read;    // issue one buffer read into the fetch stage
    } cft_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic emit_req;    // presented word closes a field
        logic fetch_free;  // fetch stage can take a read this cycle
        logic read_last;   // the read issued this cycle is the last of the field
    } cft_status_t;

    // Whitespace set used for trimming
    function automatic logic is_space(input logic [7:0] c);
        is_space = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) ||
                   (c == 8'h85) || (c == 8'hA0);
    endfunction

endpackage

`default_nettype wire

/* rtl/cft_ctrl.sv */
// Controller state machine: input acceptance and field emission sequencing.
`default_nettype none

module cft_ctrl
    import cft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire cft_status_t status,
    output cft_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && status.emit_req)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // one read per cycle while the fetch stage has room
                cmd.read = status.fetch_free;
                if (status.fetch_free && status.read_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/cft_datapath.sv */
// Datapath: quote/comma decoding, field buffer, trim tracking and output pipeline.
`default_nettype none

module cft_datapath
    import cft_pkg::*;
#(
    parameter int FIELD_DEPTH = FIELD_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire cft_cmd_t    cmd,
    output cft_status_t      status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic [2:0]       m_tuser
);

    localparam int ADDR_W = $clog2(FIELD_DEPTH);
    localparam int LEN_W  = $clog2(FIELD_DEPTH + 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(FIELD_DEPTH);
    localparam logic [LEN_W-1:0] ONE_LEN   = LEN_W'(1);

    // Field buffer
    logic [7:0] mem [FIELD_DEPTH];

    // Field parse state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] first_reg, first_next;
    logic [LEN_W-1:0]  last_reg, last_next;
    logic              inside_reg, inside_next;
    logic              pending_reg, pending_next;
    logic              saw_reg, saw_next;
    logic              ovf_reg, ovf_next;

    // Emit window
    logic [LEN_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]  hi_reg, hi_next;
    logic              marker_reg, marker_next;
    logic              line_reg, line_next;
    logic              trunc_reg, trunc_next;

    // Fetch stage and output register
    logic              f_valid_reg, f_valid_next;
    logic              f_has_reg, f_last_reg, f_line_reg, f_trunc_reg;
    logic [7:0]        rd_data_reg;
    logic              o_valid_reg, o_valid_next;
    logic [7:0]        o_data_reg;
    logic              o_last_reg, o_has_reg, o_line_reg, o_trunc_reg;

    logic              is_eol, is_q, is_comma, inside_e, append, wr_en, f_adv, f_last;
    logic              emit_req, fetch_free;
    logic              eff_saw;
    logic [LEN_W-1:0]  lo, hi;

    // Status back to the controller
    assign status = {emit_req, fetch_free, f_last};

    // Decode of the presented word
    always_comb
    begin
        is_eol   = (s_tuser == CMD_EOL);
        is_q     = (s_tdata == QUOTE_BYTE);
        is_comma = (s_tdata == COMMA_BYTE);
        inside_e = inside_reg & ~pending_reg;
        emit_req = is_eol || (is_comma && !inside_e);
        append = !is_eol &&
                 ((pending_reg && is_q) || (!is_q && !(is_comma && !inside_e)));
    end

    // Emit window: quoted fields verbatim, others trimmed
    always_comb
    begin
        eff_saw = saw_reg | pending_reg;
        if (eff_saw)
        begin
            lo = '0;
            hi = len_reg;
        end
        else if (last_reg != '0)
        begin
            lo = LEN_W'(first_reg);
            hi = last_reg;
        end
        else
        begin
            lo = '0;
            hi = '0;
        end
    end

    // Parse state update
    always_comb
    begin
        len_next     = len_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        inside_next  = inside_reg;
        pending_next = pending_reg;
        saw_next     = saw_reg;
        ovf_next     = ovf_reg;
        wr_en        = 1'b0;
        if (cmd.take)
        begin
            if (emit_req)
            begin
                len_next     = '0;
                first_next   = '0;
                last_next    = '0;
                inside_next  = 1'b0;
                pending_next = 1'b0;
                saw_next     = 1'b0;
                ovf_next     = 1'b0;
            end
            else
            begin
                pending_next = 1'b0;
                // pending quote followed by a non-quote closes quoted mode
                if (pending_reg && !is_q)
                begin
                    inside_next = 1'b0;
                    saw_next    = 1'b1;
                end
                if (!pending_reg && is_q)
                begin
                    if (inside_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        inside_next = 1'b1;
                        saw_next    = 1'b1;
                    end
                end
                if (append)
                begin
                    if (len_reg >= DEPTH_LEN)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + ONE_LEN;
                        if (!is_space(s_tdata))
                        begin
                            if (last_reg == '0)
                            begin
                                first_next = len_reg[ADDR_W-1:0];
                            end
                            last_next = len_reg + ONE_LEN;
                        end
                    end
                end
            end
        end
    end

    // Emit window and read pipeline control
    always_comb
    begin
        f_last     = marker_reg || ((rd_ptr_reg + ONE_LEN) == hi_reg);
        f_adv      = f_valid_reg && (!o_valid_reg || m_tready);
        fetch_free = !f_valid_reg || f_adv;

        rd_ptr_next = rd_ptr_reg;
        hi_next     = hi_reg;
        marker_next = marker_reg;
        line_next   = line_reg;
        trunc_next  = trunc_reg;
        if (cmd.start)
        begin
            rd_ptr_next = lo;
            hi_next     = hi;
            marker_next = (lo >= hi);
            line_next   = is_eol;
            trunc_next  = ovf_reg;
        end
        else if (cmd.read)
        begin
            rd_ptr_next = rd_ptr_reg + ONE_LEN;
        end

        f_valid_next = f_valid_reg;
        if (cmd.read)
        begin
            f_valid_next = 1'b1;
        end
        else if (f_adv)
        begin
            f_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (f_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            inside_reg  <= 1'b0;
            pending_reg <= 1'b0;
            saw_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            rd_ptr_reg  <= '0;
            hi_reg      <= '0;
            marker_reg  <= 1'b0;
            line_reg    <= 1'b0;
            trunc_reg   <= 1'b0;
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            inside_reg  <= inside_next;
            pending_reg <= pending_next;
            saw_reg     <= saw_next;
            ovf_reg     <= ovf_next;
            rd_ptr_reg  <= rd_ptr_next;
            hi_reg      <= hi_next;
            marker_reg  <= marker_next;
            line_reg    <= line_next;
            trunc_reg   <= trunc_next;
            f_valid_reg <= f_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    // Fetch stage tags and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            f_has_reg   <= !marker_reg;
            f_last_reg  <= f_last;
            f_line_reg  <= line_reg;
            f_trunc_reg <= trunc_reg;
        end
        if (f_adv)
        begin
            o_data_reg  <= f_has_reg ? rd_data_reg : 8'h00;
            o_has_reg   <= f_has_reg;
            o_last_reg  <= f_last_reg;
            o_line_reg  <= f_line_reg;
            o_trunc_reg <= f_trunc_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_trunc_reg, o_line_reg, o_has_reg};

endmodule

`default_nettype wire

/* rtl/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer: controller, datapath and checks.
//
//  Channel   Dir  tdata            tuser                                tlast
//  s_*       in   [7:0] ch         [0] cmd (0 char, 1 end of line)      -
//  m_*       out  [7:0] ch_out     [0] has_char [1] line_end [2] trunc  field_end
//
// A character word that does not close a field is taken without leaving the idle state.
// A comma outside quotes or an end-of-line word is taken, then the field is
// read out of the buffer memory at one byte per cycle while the output accepts
// (trimmed, or verbatim if quoted, or a single empty-field marker) before the next word.
// The buffer's single read port and its registered read set the flush rate.
// Output stalls hold the read pipeline; no word is lost. Reset (rst_n low)
// clears all control state at once; the buffer itself is not cleared.
`default_nettype none

module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int FIELD_DEPTH = FIELD_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       s_tuser,   // [0] cmd
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] ch_out
    output logic            m_tlast,
    output logic [2:0]      m_tuser    // [0] has_char, [1] line_end, [2] truncated
);

    cft_cmd_t    cmd;
    cft_status_t status;

    cft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cft_datapath #(
        .FIELD_DEPTH (FIELD_DEPTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An empty-field marker is always the last word of its field
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty-field marker without field_end");

    // A marker carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("empty-field marker with nonzero data");

    // End of line always starts a flush, so input is closed in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_EOL)) |=> !s_tready)
        else $error("input still open after end of line");

endmodule

`default_nettype wire
